// ----- rtl/adjls_pkg.sv -----
package adjls_pkg;

    // Vertex numbers are fixed at eight bits by the item format
    localparam int VTX_W = 8;

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Input beat
    typedef struct packed {
        logic             op;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic connected;
        logic status;
    } t_out_item;

endpackage

// ----- rtl/adjls_deg_store.sv -----
module adjls_deg_store
    import adjls_pkg::*;
#(
    parameter int ROWS  = 256,
    parameter int DEG_W = 9
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [$clog2(ROWS)-1:0] i_waddr,
    input  logic [DEG_W-1:0]        i_wdata,
    input  logic [$clog2(ROWS)-1:0] i_raddr,
    output logic [DEG_W-1:0]        o_rdata
);

    logic [DEG_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]  r_vld;
    logic [DEG_W-1:0] r_rd_data;
    logic             r_rd_vld;

    // Per-row valid bits: a row never written reads as a zero degree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    // Counter array, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- rtl/adjls_nbr_store.sv -----
module adjls_nbr_store
    import adjls_pkg::*;
#(
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [VTX_W-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [VTX_W-1:0]         o_rdata
);

    logic [VTX_W-1:0] r_mem [DEPTH];
    logic [VTX_W-1:0] r_rd_data;

    // Neighbour lists, row-major; contents undefined until written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd_data;

endmodule

// ----- rtl/adjls_ctrl.sv -----
module adjls_ctrl
    import adjls_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int ROWS         = 256,
    parameter int DEG_W        = 9,
    parameter int NA_W         = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  t_in_item                i_in_item,
    output logic                    o_in_stall,
    input  logic                    i_out_free,
    output logic                    o_done,
    output t_out_item               o_result,
    output logic                    o_deg_we,
    output logic [$clog2(ROWS)-1:0] o_deg_waddr,
    output logic [DEG_W-1:0]        o_deg_wdata,
    output logic [$clog2(ROWS)-1:0] o_deg_raddr,
    input  logic [DEG_W-1:0]        i_deg_rdata,
    output logic                    o_nbr_we,
    output logic [NA_W-1:0]         o_nbr_waddr,
    output logic [VTX_W-1:0]        o_nbr_wdata,
    output logic [NA_W-1:0]         o_nbr_raddr,
    input  logic [VTX_W-1:0]        i_nbr_rdata
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam logic [VTX_W:0] ROWS_X  = (VTX_W+1)'(ROWS);
    localparam logic [DEG_W:0] MAX_X   = (DEG_W+1)'(MAX_VERTICES);
    localparam logic [NA_W-1:0] STRIDE = NA_W'(MAX_VERTICES);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_RDA  = 8'b0000_0010,
        ST_RDB  = 8'b0000_0100,
        ST_DEC  = 8'b0000_1000,
        ST_WR1  = 8'b0001_0000,
        ST_WR2  = 8'b0010_0000,
        ST_SCAN = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic              r_op;
    logic [VTX_W-1:0]  r_a, r_b;
    logic [DEG_W-1:0]  r_deg_a, n_deg_a;
    logic [DEG_W-1:0]  r_deg_b, n_deg_b;
    logic [VTX_W-1:0]  r_own, n_own;
    logic [VTX_W-1:0]  r_tgt, n_tgt;
    logic [DEG_W-1:0]  r_scan_n, n_scan_n;
    logic [DEG_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_conn, n_conn;
    logic              r_status, n_status;

    logic              accept;
    logic              a_ok, b_ok, self_loop;
    logic [DEG_W:0]    deg_a_x, deg_b_x;
    logic              full;
    logic              own_is_b;
    logic [DEG_W-1:0]  deg_a_p1, deg_b_p1;
    logic              issue, hit;

    // Linear neighbour address of entry col in row
    function automatic logic [NA_W-1:0] nbr_addr(input logic [ROW_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
        nbr_addr = NA_W'(row) * STRIDE + NA_W'(col);
    endfunction

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // Range, self-loop and room checks on the latched item
    assign a_ok      = ({1'b0, r_a} < ROWS_X);
    assign b_ok      = ({1'b0, r_b} < ROWS_X);
    assign self_loop = (r_a == r_b);
    assign deg_a_x   = {1'b0, r_deg_a};
    assign deg_b_x   = {1'b0, i_deg_rdata};
    assign full      = self_loop ? ((deg_a_x + (DEG_W+1)'(2)) > MAX_X)
                                 : (((deg_a_x + (DEG_W+1)'(1)) > MAX_X) ||
                                    ((deg_b_x + (DEG_W+1)'(1)) > MAX_X));
    assign own_is_b  = (i_deg_rdata < r_deg_a);
    assign deg_a_p1  = r_deg_a + DEG_W'(1);
    assign deg_b_p1  = r_deg_b + DEG_W'(1);

    // Compare unit of the scan: one list entry a cycle
    assign issue = (r_idx < r_scan_n);
    assign hit   = r_pend && (i_nbr_rdata == r_tgt);

    // Degree port
    always_comb begin
        o_deg_raddr = (r_state == ST_RDB) ? r_b[ROW_W-1:0] : r_a[ROW_W-1:0];
        o_deg_we    = 1'b0;
        o_deg_waddr = r_a[ROW_W-1:0];
        o_deg_wdata = self_loop ? (r_deg_a + DEG_W'(2)) : deg_a_p1;
        if (r_state == ST_WR1) begin
            o_deg_we = 1'b1;
        end else if (r_state == ST_WR2) begin
            o_deg_we    = !self_loop;
            o_deg_waddr = r_b[ROW_W-1:0];
            o_deg_wdata = deg_b_p1;
        end
    end

    // Neighbour port
    always_comb begin
        o_nbr_raddr = nbr_addr(r_own[ROW_W-1:0], r_idx[IDX_W-1:0]);
        o_nbr_we    = (r_state == ST_WR1) || (r_state == ST_WR2);
        o_nbr_waddr = nbr_addr(r_a[ROW_W-1:0], r_deg_a[IDX_W-1:0]);
        o_nbr_wdata = self_loop ? r_a : r_b;
        if (r_state == ST_WR2) begin
            o_nbr_wdata = r_a;
            o_nbr_waddr = self_loop ? nbr_addr(r_a[ROW_W-1:0], deg_a_p1[IDX_W-1:0])
                                    : nbr_addr(r_b[ROW_W-1:0], r_deg_b[IDX_W-1:0]);
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_deg_a  = r_deg_a;
        n_deg_b  = r_deg_b;
        n_own    = r_own;
        n_tgt    = r_tgt;
        n_scan_n = r_scan_n;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_conn   = r_conn;
        n_status = r_status;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state  = ST_RDA;
                    n_conn   = 1'b0;
                    n_status = STATUS_DONE;
                end
            end
            ST_RDA: begin
                n_state = ST_RDB;
            end
            ST_RDB: begin
                n_deg_a = i_deg_rdata;
                n_state = ST_DEC;
            end
            ST_DEC: begin
                n_deg_b = i_deg_rdata;
                if (r_op == OP_ADD) begin
                    if (!a_ok || !b_ok || full) begin
                        n_status = STATUS_FULL;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_WR1;
                    end
                end else if (self_loop) begin
                    n_conn  = 1'b1;
                    n_state = ST_DONE;
                end else if (!a_ok || !b_ok) begin
                    n_state = ST_DONE;
                end else begin
                    n_own    = own_is_b ? r_b : r_a;
                    n_tgt    = own_is_b ? r_a : r_b;
                    n_scan_n = own_is_b ? i_deg_rdata : r_deg_a;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_state  = ST_SCAN;
                end
            end
            ST_WR1: begin
                n_state = ST_WR2;
            end
            ST_WR2: begin
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                n_pend = issue;
                if (hit) begin
                    n_conn  = 1'b1;
                    n_state = ST_DONE;
                end else if (!issue && !r_pend) begin
                    n_state = ST_DONE;
                end else if (issue) begin
                    n_idx = r_idx + DEG_W'(1);
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_in_item.op;
            r_a  <= i_in_item.vertex_a;
            r_b  <= i_in_item.vertex_b;
        end
        r_deg_a  <= n_deg_a;
        r_deg_b  <= n_deg_b;
        r_own    <= n_own;
        r_tgt    <= n_tgt;
        r_scan_n <= n_scan_n;
        r_idx    <= n_idx;
        r_conn   <= n_conn;
        r_status <= n_status;
    end

    assign o_done             = (r_state == ST_DONE) && i_out_free;
    assign o_result.connected = r_conn;
    assign o_result.status    = r_status;

`ifndef SYNTHESIS
    a_add_no_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_op == OP_ADD) |-> !o_result.connected)
        else $error("add produced a connected result");
    a_query_no_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_op == OP_QUERY) |-> (o_result.status == STATUS_DONE))
        else $error("query produced a full status");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_scan_n))
        else $error("scan index ran past list length");
    a_deg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_deg_we |-> ({1'b0, o_deg_wdata} <= MAX_X))
        else $error("degree written above list capacity");
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RDA))
        else $error("accepted beat did not start degree read");
`endif

endmodule

// ----- rtl/adjacency_list_edge_store_core.sv -----
// Channel | Valid      | Stall       | Payload
// input   | i_in_valid | o_in_stall  | i_in_item  (t_in_item: op, vertex_a, vertex_b)
// output  | o_out_valid| i_out_stall | o_out_item (t_out_item: connected, status)
//
// Add: two degree reads, a decide step and two writes from accept to result register;
// a refused add goes from decide straight to the result. Query: after the reads and decide,
// a scan of the shorter list (its degree up to MAX_VERTICES) that ends early on a hit; equal
// or out-of-range vertices finish at decide. Beats are taken only in the idle state.
// Reset clears the per-row degree valid bits at once; the neighbour memory is not cleared.
// A result waits in the output register while the next beat is taken; the sequencer holds
// its result only when that register is still full and stalled.
module adjacency_list_edge_store_core
    import adjls_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int ROWS  = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
    localparam int ROW_W = $clog2(ROWS);
    localparam int DEG_W = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = ROWS * MAX_VERTICES;
    localparam int NA_W  = $clog2(DEPTH);

    logic             out_free;
    logic             done;
    t_out_item        result;
    logic             deg_we;
    logic [ROW_W-1:0] deg_waddr, deg_raddr;
    logic [DEG_W-1:0] deg_wdata, deg_rdata;
    logic             nbr_we;
    logic [NA_W-1:0]  nbr_waddr, nbr_raddr;
    logic [VTX_W-1:0] nbr_wdata, nbr_rdata;
    logic             r_out_valid;
    t_out_item        r_out_item;

    assign out_free = !r_out_valid || !i_out_stall;

    adjls_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .ROWS         (ROWS),
        .DEG_W        (DEG_W),
        .NA_W         (NA_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_out_free  (out_free),
        .o_done      (done),
        .o_result    (result),
        .o_deg_we    (deg_we),
        .o_deg_waddr (deg_waddr),
        .o_deg_wdata (deg_wdata),
        .o_deg_raddr (deg_raddr),
        .i_deg_rdata (deg_rdata),
        .o_nbr_we    (nbr_we),
        .o_nbr_waddr (nbr_waddr),
        .o_nbr_wdata (nbr_wdata),
        .o_nbr_raddr (nbr_raddr),
        .i_nbr_rdata (nbr_rdata)
    );

    adjls_deg_store #(
        .ROWS  (ROWS),
        .DEG_W (DEG_W)
    ) u_deg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    adjls_nbr_store #(
        .DEPTH (DEPTH)
    ) u_nbr (
        .i_clk   (i_clk),
        .i_we    (nbr_we),
        .i_waddr (nbr_waddr),
        .i_wdata (nbr_wdata),
        .i_raddr (nbr_raddr),
        .o_rdata (nbr_rdata)
    );

    // Output register: holds a result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
